// ===== hdl/ins_pkg.sv =====
// ins_pkg: shared types and constants for the insertion sorter.
// Holds the request/response item structs, the back-end state enum and the
// front queue head struct. No dependencies.
package ins_pkg;

   // Depth of the queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // One input item
   typedef struct packed {
      logic signed [31:0] value;
      logic               last_in;
   } ins_req_type;

   // One result item
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
      logic               overflow;
   } ins_rsp_type;

   // Head of the front queue as seen by the back end
   typedef struct packed {
      logic        valid;
      ins_req_type item;
   } ins_qhead_type;

   // Back-end sequencing
   typedef enum logic {
      INS_LOAD,
      INS_DRAIN
   } ins_state_type;

endpackage

// ===== hdl/ins_front.sv =====
// ins_front: input side of the insertion sorter, a short item queue.
// Decouples the request handshake from the sorting back end.
// Depends on ins_pkg.
module ins_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  ins_pkg::ins_req_type  req_item,
   output ins_pkg::ins_qhead_type head,
   input  logic                  head_pop
);

   localparam int PTR_W = (ins_pkg::QUEUE_DEPTH > 1) ? $clog2(ins_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ins_pkg::QUEUE_DEPTH + 1);

   ins_pkg::ins_req_type queue_ff [ins_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == CNT_W'(ins_pkg::QUEUE_DEPTH));
   assign do_wr = push && !full;
   assign do_rd = head_pop && (count_ff != '0);

   // Head of queue
   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ins_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ins_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         queue_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== hdl/ins_back.sv =====
// ins_back: sorting back end, a compare-and-shift cell array with a drain
// sequencer and an output register. Depends on ins_pkg.
module ins_back #(
   parameter int CAPACITY = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ins_pkg::ins_qhead_type head,
   output logic                   head_pop,
   output logic                   empty,
   input  logic                   pop,
   output ins_pkg::ins_rsp_type   rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   ins_pkg::ins_state_type state_ff, state_in;
   logic signed [31:0] cell_ff [CAPACITY];
   logic signed [31:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0] lt;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ins_pkg::ins_rsp_type rsp_data_ff, rsp_data_in;
   logic                shift_out, do_ins, final_out;
   logic signed [31:0]  new_value;

   assign new_value = head.item.value;
   assign do_ins    = head_pop && (count_ff < CNT_W'(CAPACITY));
   assign final_out = shift_out && (count_ff == CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ins_pkg::INS_LOAD: begin
            if (head.valid && head.item.last_in) begin
               state_in = ins_pkg::INS_DRAIN;
            end
         end
         ins_pkg::INS_DRAIN: begin
            if (final_out) begin
               state_in = ins_pkg::INS_LOAD;
            end
         end
         default: state_in = ins_pkg::INS_LOAD;
      endcase
   end

   // State outputs
   always_comb begin
      head_pop  = 1'b0;
      shift_out = 1'b0;
      case (state_ff)
         ins_pkg::INS_LOAD:  head_pop  = head.valid;
         ins_pkg::INS_DRAIN: shift_out = !rsp_valid_ff || pop;
         default: begin
            head_pop  = 1'b0;
            shift_out = 1'b0;
         end
      endcase
   end

   // Per-cell compare: stored value strictly below the new one
   // Cell update: hold below the insertion point, take the new value at it,
   // shift up above it; during drain everything moves down one place.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign lt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] < new_value);

      if (i == 0) begin : g_first
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_ins) begin
               cell_in[i] = lt[i] ? cell_ff[i] : new_value;
            end else if (shift_out) begin
               cell_in[i] = (CAPACITY > 1) ? cell_ff[(i + 1) % CAPACITY] : cell_ff[i];
            end
         end
      end else if (i == CAPACITY - 1) begin : g_last
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_ins) begin
               cell_in[i] = lt[i] ? cell_ff[i] : (lt[i-1] ? new_value : cell_ff[i-1]);
            end
         end
      end else begin : g_mid
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_ins) begin
               cell_in[i] = lt[i] ? cell_ff[i] : (lt[i-1] ? new_value : cell_ff[i-1]);
            end else if (shift_out) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Fill count, drop flag and output register
   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (shift_out) begin
         count_in = count_ff - 1'b1;
      end
      if (final_out) begin
         dropped_in = 1'b0;
      end else if (head_pop && !do_ins) begin
         dropped_in = 1'b1;
      end
      if (shift_out) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = cell_ff[0];
         rsp_data_in.last_out     = (count_ff == CNT_W'(1));
         rsp_data_in.overflow     = dropped_ff;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ins_pkg::INS_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_data_ff;

endmodule

// ===== hdl/insertion_sorter.sv =====
// insertion_sorter: values load at one item per cycle, except while the array drains, into a
// compare-and-shift cell array; an item flagged last starts the drain of N results, one per
// cycle while results are popped. With the array idle, the last item passes the front queue
// and cell array before the first result reaches the output register. Input stalls (full)
// while the array drains; the two-entry front queue absorbs up to two items meanwhile. Reset
// is synchronous and clears count, flags and handshake state; no clearing pass is needed.
module insertion_sorter #(
   parameter int CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ins_pkg::ins_req_type req_item,
   output logic                 empty,
   input  logic                 pop,
   output ins_pkg::ins_rsp_type rsp_item
);

   ins_pkg::ins_qhead_type head;
   logic                   head_pop;

   // Input queue
   ins_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .head     (head),
      .head_pop (head_pop)
   );

   // Sorting array and output register
   ins_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== hdl/ins_checker.sv =====
// ins_checker: port-level checks for the insertion sorter, bound to the top.
// Depends on ins_pkg and insertion_sorter.
module ins_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 full,
   input logic                 empty,
   input logic                 pop,
   input ins_pkg::ins_rsp_type rsp_item
);

   logic               have_prev_ff;
   logic signed [31:0] prev_value_ff;
   logic               prev_ovf_ff;
   logic               take;

   assign take = pop && !empty;

   // Track the previous result of the current run
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (take) begin
         have_prev_ff <= !rsp_item.last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prev_value_ff <= rsp_item.sorted_value;
         prev_ovf_ff   <= rsp_item.overflow;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("results present after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("queue full after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (take && have_prev_ff) |-> (rsp_item.sorted_value >= prev_value_ff))
      else $error("run not ascending");

   a_overflow_const: assert property (@(posedge clock) disable iff (reset)
      (take && have_prev_ff) |-> (rsp_item.overflow == prev_ovf_ff))
      else $error("overflow flag changed within a run");

endmodule

bind insertion_sorter ins_checker u_ins_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for insertion_sorter, driving sets of signed values
// through the push/full side and checking sorted runs on the empty/pop side.
// Depends on hdl/ins_pkg.sv and hdl/insertion_sorter.sv.
`timescale 1ns / 100ps

module tb_top;

   localparam int CAPACITY = 32;
   localparam int RANDOM_ITEMS = 130;

   // Receiver stall patterns
   typedef enum int {
      RX_STREAM,
      RX_COIN,
      RX_SPARSE,
      RX_LONG_STALL
   } rx_mode_type;

   // One item waiting to be sent; hold makes the sender wait for all results first
   typedef struct packed {
      ins_pkg::ins_req_type item;
      logic                 hold;
   } pending_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   ins_pkg::ins_req_type req_item = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   ins_pkg::ins_rsp_type rsp_item;

   pending_type          pending_q[$];
   ins_pkg::ins_rsp_type sorted_q[$];

   // Shadow of the sorter contents
   logic signed [31:0] shadow_store[CAPACITY];
   int                 shadow_count;
   logic               shadow_dropped;

   int error_count;
   int items_sent;
   int sets_sent;
   int overflow_sets;
   int results_checked;

   // Sender burst bookkeeping
   int burst_left;
   int gap_left;

   // Receiver pattern bookkeeping
   rx_mode_type rx_mode;
   int          rx_left;

   insertion_sorter #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_item(req_item),
      .empty   (empty),
      .pop     (pop),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Insert one accepted item into the shadow store; a closing item emits the run
   task automatic sort_and_emit(input ins_pkg::ins_req_type it);
      int                   pos;
      ins_pkg::ins_rsp_type r;
      pos = 0;
      if (shadow_count >= CAPACITY) begin
         shadow_dropped = 1'b1;
      end else begin
         while (pos < shadow_count && shadow_store[pos] < it.value) pos++;
         for (int i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i - 1];
         shadow_store[pos] = it.value;
         shadow_count++;
      end
      if (it.last_in) begin
         for (int k = 0; k < shadow_count; k++) begin
            r.sorted_value = shadow_store[k];
            r.last_out     = (k == shadow_count - 1);
            r.overflow     = shadow_dropped;
            sorted_q.push_back(r);
         end
         sets_sent++;
         if (shadow_dropped) overflow_sets++;
         shadow_count   = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      int sel;
      int near;
      sel  = $urandom_range(0, 9);
      near = $urandom_range(0, 15);
      case (sel)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return near - 8;  // narrow range gives many equal values
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input logic signed [31:0] v, input logic last, input logic hold);
      pending_type p;
      p.item.value   = v;
      p.item.last_in = last;
      p.hold         = hold;
      pending_q.push_back(p);
   endtask

   task automatic add_random_set(input int n, input logic hold);
      for (int i = 0; i < n; i++) add_item(pick_value(), i == n - 1, hold && i == 0);
   endtask

   // Sender: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         push       <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (push && !full) begin
            sort_and_emit(req_item);
            void'(pending_q.pop_front());
            items_sent++;
         end
         if (push && full) begin
            // offer stays up until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push     <= 1'b0;
         end else if (pending_q.size() == 0) begin
            push <= 1'b0;
         end else if (pending_q[0].hold && sorted_q.size() != 0) begin
            push <= 1'b0;
         end else begin
            push     <= 1'b1;
            req_item <= pending_q[0].item;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver: checks each popped item against the oldest expectation
   always @(posedge clock) begin
      ins_pkg::ins_rsp_type want;
      if (reset) begin
         pop     <= 1'b0;
         rx_mode <= RX_STREAM;
         rx_left <= 0;
      end else begin
         if (pop && !empty) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected result: value %0d last %0b overflow %0b",
                      rsp_item.sorted_value, rsp_item.last_out, rsp_item.overflow);
               error_count++;
            end else begin
               want = sorted_q.pop_front();
               results_checked++;
               if (rsp_item.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_item.sorted_value);
                  error_count++;
               end
               if (rsp_item.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_item.last_out);
                  error_count++;
               end
               if (rsp_item.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_item.overflow);
                  error_count++;
               end
            end
         end
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_STREAM: pop <= 1'b1;
            RX_COIN:   pop <= $urandom_range(0, 1);
            RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:   pop <= (rx_left % 24) >= 20;
         endcase
      end
   end

   // Stimulus and end of run
   initial begin
      int random_added;
      int n;
      error_count     = 0;
      items_sent      = 0;
      sets_sent       = 0;
      overflow_sets   = 0;
      results_checked = 0;
      shadow_count    = 0;
      shadow_dropped  = 1'b0;

      // Single-value sets at both extremes
      add_item(32'sh7fff_ffff, 1'b1, 1'b0);
      add_item(32'sh8000_0000, 1'b1, 1'b0);
      // Mixed extremes around zero, sent after the pipe has drained
      add_item(32'sd0, 1'b0, 1'b1);
      add_item(-32'sd1, 1'b0, 1'b0);
      add_item(32'sh7fff_ffff, 1'b0, 1'b0);
      add_item(32'sh8000_0000, 1'b0, 1'b0);
      add_item(32'sd1, 1'b1, 1'b0);
      // Equal values
      add_item(32'sd5, 1'b0, 1'b0);
      add_item(32'sd5, 1'b0, 1'b0);
      add_item(-32'sd3, 1'b0, 1'b0);
      add_item(32'sd5, 1'b0, 1'b0);
      add_item(-32'sd3, 1'b1, 1'b0);
      // Descending input
      add_item(32'sd30, 1'b0, 1'b0);
      add_item(32'sd20, 1'b0, 1'b0);
      add_item(32'sd10, 1'b0, 1'b0);
      add_item(32'sd0, 1'b0, 1'b0);
      add_item(-32'sd10, 1'b1, 1'b0);
      // Ascending input
      add_item(-32'sd2, 1'b0, 1'b0);
      add_item(-32'sd1, 1'b0, 1'b0);
      add_item(32'sd0, 1'b0, 1'b0);
      add_item(32'sd1, 1'b1, 1'b0);

      // Store exactly full, then one over so the closing item itself is dropped
      add_random_set(CAPACITY, 1'b0);
      add_random_set(CAPACITY + 1, 1'b1);
      random_added = 2 * CAPACITY + 1;
      while (random_added < RANDOM_ITEMS) begin
         if ($urandom_range(0, 11) == 0) n = $urandom_range(CAPACITY - 1, CAPACITY + 4);
         else n = $urandom_range(1, 8);
         add_random_set(n, $urandom_range(0, 9) == 0);
         random_added += n;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (CAPACITY + 20) @(posedge clock);

      if (sorted_q.size() != 0) begin
         $error("%0d expected results never arrived", sorted_q.size());
         error_count++;
      end
      $display("Sent %0d items in %0d sets (%0d overflowed), checked %0d sorted results.",
               items_sent, sets_sent, overflow_sets, results_checked);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
